// File: src/pssel_pkg.sv
// shared constants, codes and controller/datapath interface types
// for the polyline start point selector; no dependencies
package pssel_pkg;

	localparam int MAX_POINTS_DEF = 1024;
	localparam int COORD_BITS_DEF = 24;

	localparam int LAYER_W   = 16;
	localparam int DTHR_W    = 25;
	localparam int WTHR_W    = 35;
	localparam int IDX_OUT_W = 10;
	localparam int STATUS_W  = 2;
	localparam int MODE_W    = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = WTHR_W;

	localparam logic [MODE_W-1:0] MODE_NEAREST  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FARTHEST = 2'd1;
	localparam logic [MODE_W-1:0] MODE_WALK     = 2'd2;
	localparam logic [MODE_W-1:0] MODE_PLAIN    = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_SELECT_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THR_ENABLE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DIST_THR    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WALK_THR    = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_DROPPED = 2'd2;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	localparam logic [1:0] BOUND_T2   = 2'd0;
	localparam logic [1:0] BOUND_ZERO = 2'd1;
	localparam logic [1:0] BOUND_MAX  = 2'd2;

	typedef struct packed {
		logic       q_latch;
		logic       a_latch;
		logic       issue;
		logic       walk;
		logic       init_search;
		logic       search_near;
		logic [1:0] bound_sel;
		logic       mod_step;
		logic       sum_clr;
	} dp_cmd_t;

	typedef struct packed {
		logic pipe_busy;
		logic sqrt_busy;
		logic found;
		logic sum_reached;
		logic overflow;
	} dp_stat_t;

endpackage

// File: src/pssel_datapath.sv
// point memory, configuration registers, distance pipeline, search compare,
// serial square root and layer modulo; uses pssel_pkg
module pssel_datapath import pssel_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF,
	localparam int IW = $clog2(MAX_POINTS),
	localparam int CW = $clog2(MAX_POINTS + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DAT_W-1:0]        cfg_data,
	input  logic                        ld_en,
	input  logic                        ld_first,
	input  logic signed [COORD_BITS-1:0] pos_x,
	input  logic signed [COORD_BITS-1:0] pos_y,
	input  logic [LAYER_W-1:0]          layer,
	input  dp_cmd_t                     cmd,
	input  logic [CW-1:0]               addr,
	output dp_stat_t                    stat,
	output logic [CW-1:0]               count,
	output logic [IW-1:0]               best_idx,
	output logic [CW-1:0]               lmod,
	output logic [MODE_W-1:0]           mode,
	output logic                        thr_en
);

	localparam int C    = COORD_BITS;
	localparam int DW   = 2 * C + 1;
	localparam int T2W  = 2 * DTHR_W;
	localparam int BW   = (DW > T2W) ? DW : T2W;
	localparam int SQ   = C + 1;
	localparam int VW   = 2 * SQ;
	localparam int SW   = SQ + CW;
	localparam int CMPW = (SW > WTHR_W) ? SW : WTHR_W;

	logic signed [C-1:0] mem_x [MAX_POINTS];
	logic signed [C-1:0] mem_y [MAX_POINTS];

	logic [MODE_W-1:0] mode_q;
	logic              thr_en_q;
	logic [DTHR_W-1:0] dthr_q;
	logic [WTHR_W-1:0] wthr_q;
	logic [T2W-1:0]    t2;

	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic [CW-1:0] eff_cnt;
	logic          room;

	logic signed [C-1:0] rx_s1, ry_s1;
	logic signed [C-1:0] ax_q, ay_q;
	logic signed [C:0]   dxs, dys;
	logic [C:0]          dxm, dym;
	logic [C-1:0]        dx_s2, dy_s2;
	logic [2*C-1:0]      sqx_s3, sqy_s3;
	logic [DW-1:0]       d_s4;
	logic                v_s1, v_s2, v_s3, v_s4;
	logic [IW-1:0]       idx_s1, idx_s2, idx_s3, idx_s4;

	logic [BW-1:0] best_q;
	logic [IW-1:0] bidx_q;
	logic          found_q;
	logic          near_q;
	logic [BW-1:0] d_ext;
	logic          better;

	logic          sq_busy_q;
	logic [VW-1:0] sv_q, sr_q, sb_q;
	logic [VW:0]   rb;
	logic [SW-1:0] sum_q;

	logic [LAYER_W-1:0] lay_q;
	logic [CW-1:0]      rem_q;
	logic [CW:0]        rem_t;

	assign eff_cnt = ld_first ? '0 : count_q;
	assign room    = eff_cnt < CW'(MAX_POINTS);

	// point storage
	always_ff @(posedge clk) begin
		if (ld_en && room) begin
			mem_x[eff_cnt[IW-1:0]] <= pos_x;
			mem_y[eff_cnt[IW-1:0]] <= pos_y;
		end
		rx_s1 <= mem_x[addr[IW-1:0]];
		ry_s1 <= mem_y[addr[IW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_NEAREST;
			thr_en_q <= 1'b0;
			dthr_q   <= '0;
			wthr_q   <= '0;
			count_q  <= '0;
			ovf_q    <= 1'b0;
		end else begin
			if (cfg_wr) begin
				case (cfg_index)
					CFG_SELECT_MODE: mode_q   <= cfg_data[MODE_W-1:0];
					CFG_THR_ENABLE:  thr_en_q <= cfg_data[0];
					CFG_DIST_THR:    dthr_q   <= cfg_data[DTHR_W-1:0];
					CFG_WALK_THR:    wthr_q   <= cfg_data[WTHR_W-1:0];
					default: ;
				endcase
			end
			if (ld_en) begin
				if (room) begin
					count_q <= eff_cnt + CW'(1);
					if (ld_first)
						ovf_q <= 1'b0;
				end else begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	assign t2 = T2W'(dthr_q) * T2W'(dthr_q);

	// distance pipeline
	assign dxs = {ax_q[C-1], ax_q} - {rx_s1[C-1], rx_s1};
	assign dys = {ay_q[C-1], ay_q} - {ry_s1[C-1], ry_s1};
	assign dxm = dxs[C] ? -dxs : dxs;
	assign dym = dys[C] ? -dys : dys;

	always_ff @(posedge clk) begin
		if (cmd.q_latch) begin
			ax_q <= pos_x;
			ay_q <= pos_y;
		end else if (cmd.a_latch) begin
			ax_q <= rx_s1;
			ay_q <= ry_s1;
		end
		dx_s2  <= dxm[C-1:0];
		dy_s2  <= dym[C-1:0];
		sqx_s3 <= dx_s2 * dx_s2;
		sqy_s3 <= dy_s2 * dy_s2;
		d_s4   <= DW'(sqx_s3) + DW'(sqy_s3);
		idx_s1 <= addr[IW-1:0];
		idx_s2 <= idx_s1;
		idx_s3 <= idx_s2;
		idx_s4 <= idx_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// search compare
	assign d_ext  = BW'(d_s4);
	assign better = near_q ? (d_ext < best_q) : (d_ext > best_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			near_q  <= 1'b0;
			bidx_q  <= '0;
			best_q  <= '0;
		end else if (cmd.init_search) begin
			found_q <= 1'b0;
			near_q  <= cmd.search_near;
			bidx_q  <= '0;
			case (cmd.bound_sel)
				BOUND_T2:   best_q <= BW'(t2);
				BOUND_ZERO: best_q <= '0;
				default:    best_q <= '1;
			endcase
		end else if (v_s4 && !cmd.walk && better) begin
			found_q <= 1'b1;
			best_q  <= d_ext;
			bidx_q  <= idx_s4;
		end
	end

	// square root, two bits a step, and segment length sum
	assign rb = {1'b0, sr_q} + {1'b0, sb_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_busy_q <= 1'b0;
			sum_q     <= '0;
		end else begin
			if (cmd.sum_clr)
				sum_q <= '0;
			if (v_s4 && cmd.walk) begin
				sq_busy_q <= 1'b1;
			end else if (sq_busy_q && sb_q == '0) begin
				sq_busy_q <= 1'b0;
				sum_q     <= sum_q + SW'(sr_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s4 && cmd.walk) begin
			sv_q <= VW'(d_s4);
			sr_q <= '0;
			sb_q <= VW'(1) << (VW - 2);
		end else if (sq_busy_q && sb_q != '0) begin
			if ({1'b0, sv_q} >= rb) begin
				sv_q <= sv_q - rb[VW-1:0];
				sr_q <= (sr_q >> 1) + sb_q;
			end else begin
				sr_q <= sr_q >> 1;
			end
			sb_q <= sb_q >> 2;
		end
	end

	// layer mod point count, one bit a step
	assign rem_t = {rem_q, lay_q[LAYER_W-1]};

	always_ff @(posedge clk) begin
		if (cmd.q_latch) begin
			lay_q <= layer;
			rem_q <= '0;
		end else if (cmd.mod_step) begin
			lay_q <= lay_q << 1;
			if (rem_t >= {1'b0, count_q})
				rem_q <= CW'(rem_t - {1'b0, count_q});
			else
				rem_q <= rem_t[CW-1:0];
		end
	end

	assign stat.pipe_busy   = v_s1 | v_s2 | v_s3 | v_s4;
	assign stat.sqrt_busy   = sq_busy_q;
	assign stat.found       = found_q;
	assign stat.sum_reached = CMPW'(sum_q) >= CMPW'(wthr_q);
	assign stat.overflow    = ovf_q;

	assign count    = count_q;
	assign best_idx = bidx_q;
	assign lmod     = rem_q;
	assign mode     = mode_q;
	assign thr_en   = thr_en_q;

endmodule

// File: src/pssel_ctrl.sv
// controller: handshakes, scan and walk sequencing, result register
// uses pssel_pkg; drives pssel_datapath through dp_cmd_t
module pssel_ctrl import pssel_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	localparam int IW = $clog2(MAX_POINTS),
	localparam int CW = $clog2(MAX_POINTS + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  kind,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [IDX_OUT_W-1:0]  start_index,
	output logic                  fell_back,
	output logic [STATUS_W-1:0]   status,
	output logic                  ld_en,
	output dp_cmd_t               cmd,
	output logic [CW-1:0]         addr,
	input  dp_stat_t              stat,
	input  logic [CW-1:0]         count,
	input  logic [IW-1:0]         best_idx,
	input  logic [CW-1:0]         lmod,
	input  logic [MODE_W-1:0]     mode,
	input  logic                  thr_en
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_MOD   = 4'd1;
	localparam logic [3:0] S_WSET  = 4'd2;
	localparam logic [3:0] S_WRA   = 4'd3;
	localparam logic [3:0] S_WRB   = 4'd4;
	localparam logic [3:0] S_WWAIT = 4'd5;
	localparam logic [3:0] S_SCAN  = 4'd6;
	localparam logic [3:0] S_DRAIN = 4'd7;
	localparam logic [3:0] S_FIN   = 4'd8;

	localparam int MCW = $clog2(LAYER_W);

	logic [3:0]           state_q;
	logic [CW-1:0]        i_q, p_q, s_q;
	logic [CW-1:0]        c_n, s_n;
	logic [MCW-1:0]       mcnt_q;
	logic                 pass2_q;
	logic                 walk_q;
	logic [IW-1:0]        res_idx_q;
	logic                 res_fell_q;
	logic [STATUS_W-1:0]  res_stat_q;
	logic                 out_valid_q;
	logic [IDX_OUT_W-1:0] start_q;
	logic                 fell_q;
	logic [STATUS_W-1:0]  stat_q;
	logic                 in_xfer, fin_load;
	logic [IW+IDX_OUT_W-1:0] idx_wide;

	assign in_ready = (state_q == S_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign ld_en    = in_xfer && (kind == KIND_LOAD);
	assign fin_load = (state_q == S_FIN) && (!out_valid_q || out_ready);

	assign c_n = (p_q + CW'(1) == count) ? '0 : p_q + CW'(1);
	assign s_n = (count == CW'(1)) ? '0 :
		(lmod >= CW'(2)) ? lmod - CW'(2) : lmod + count - CW'(2);

	always_comb begin
		cmd = '0;
		addr = '0;
		cmd.walk = walk_q;
		case (state_q)
			S_IDLE: begin
				if (in_xfer && kind == KIND_QUERY) begin
					cmd.q_latch = 1'b1;
					cmd.sum_clr = 1'b1;
					cmd.init_search = 1'b1;
					if (mode == MODE_FARTHEST) begin
						cmd.search_near = 1'b0;
						cmd.bound_sel = thr_en ? BOUND_T2 : BOUND_ZERO;
					end else begin
						cmd.search_near = 1'b1;
						cmd.bound_sel = (mode == MODE_NEAREST && thr_en) ?
							BOUND_T2 : BOUND_MAX;
					end
				end
			end
			S_MOD:  cmd.mod_step = 1'b1;
			S_WRA:  addr = p_q;
			S_WRB: begin
				cmd.a_latch = 1'b1;
				cmd.issue = 1'b1;
				addr = c_n;
			end
			S_SCAN: begin
				cmd.issue = 1'b1;
				addr = i_q;
			end
			S_DRAIN: begin
				if (!stat.pipe_busy && !stat.found && !pass2_q) begin
					cmd.init_search = 1'b1;
					cmd.search_near = 1'b0;
					cmd.bound_sel = BOUND_ZERO;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			i_q        <= '0;
			p_q        <= '0;
			s_q        <= '0;
			mcnt_q     <= '0;
			pass2_q    <= 1'b0;
			walk_q     <= 1'b0;
			res_idx_q  <= '0;
			res_fell_q <= 1'b0;
			res_stat_q <= ST_OK;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_xfer && kind == KIND_QUERY) begin
						res_idx_q  <= '0;
						res_fell_q <= 1'b0;
						pass2_q    <= 1'b0;
						i_q        <= '0;
						mcnt_q     <= '0;
						res_stat_q <= stat.overflow ? ST_DROPPED : ST_OK;
						walk_q     <= 1'b0;
						if (count == '0) begin
							res_stat_q <= ST_EMPTY;
							state_q    <= S_FIN;
						end else if (mode == MODE_WALK) begin
							walk_q  <= 1'b1;
							state_q <= S_MOD;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_MOD: begin
					mcnt_q <= mcnt_q + MCW'(1);
					if (mcnt_q == MCW'(LAYER_W - 1))
						state_q <= S_WSET;
				end
				S_WSET: begin
					s_q     <= s_n;
					p_q     <= s_n;
					state_q <= S_WRA;
				end
				S_WRA:  state_q <= S_WRB;
				S_WRB:  state_q <= S_WWAIT;
				S_WWAIT: begin
					if (!stat.pipe_busy && !stat.sqrt_busy) begin
						if (c_n == s_q || stat.sum_reached) begin
							res_idx_q <= c_n[IW-1:0];
							state_q   <= S_FIN;
						end else begin
							p_q     <= c_n;
							state_q <= S_WRA;
						end
					end
				end
				S_SCAN: begin
					i_q <= i_q + CW'(1);
					if (i_q + CW'(1) == count)
						state_q <= S_DRAIN;
				end
				S_DRAIN: begin
					if (!stat.pipe_busy) begin
						if (!stat.found && !pass2_q) begin
							pass2_q    <= 1'b1;
							res_fell_q <= 1'b1;
							i_q        <= '0;
							state_q    <= S_SCAN;
						end else begin
							res_idx_q <= stat.found ? best_idx : '0;
							state_q   <= S_FIN;
						end
					end
				end
				S_FIN: begin
					if (fin_load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result register
	assign idx_wide = {{IDX_OUT_W{1'b0}}, res_idx_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			start_q <= idx_wide[IDX_OUT_W-1:0];
			fell_q  <= res_fell_q;
			stat_q  <= res_stat_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign start_index = start_q;
	assign fell_back   = fell_q;
	assign status      = stat_q;

	a_query_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && kind == KIND_QUERY) |=> (state_q != S_IDLE))
		else $error("query transfer did not start work");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (i_q < count))
		else $error("scan address beyond stored points");

	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRA || state_q == S_WRB) |-> (p_q < count && s_q < count))
		else $error("walk index beyond stored points");

	a_fin_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		fin_load |=> out_valid_q)
		else $error("finished result not presented");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_load && res_stat_q == ST_EMPTY) |-> (res_idx_q == '0 && !res_fell_q))
		else $error("empty polyline result not zero");

endmodule

// File: src/polyline_start_point_selector.sv
// Polyline start point selector. Loads (kind 0) are taken one per cycle while the block is
// idle and write the point memory. A query (kind 1) runs, in nearest, farthest and plain
// modes, one scan pass over the point memory, and a second when the fallback pass runs;
// in walk mode it takes the layer modulo, then walks segment by segment, each length from
// the serial square root. The result is then loaded into the output register; the next
// item is taken once the query's result is loaded there. Config writes are always accepted.
// top level; uses pssel_pkg, pssel_ctrl and pssel_datapath
module polyline_start_point_selector import pssel_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DAT_W-1:0]         cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         kind,
	input  logic signed [COORD_BITS-1:0] pos_x,
	input  logic signed [COORD_BITS-1:0] pos_y,
	input  logic                         first_point,
	input  logic [LAYER_W-1:0]           layer,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [IDX_OUT_W-1:0]         start_index,
	output logic                         fell_back,
	output logic [STATUS_W-1:0]          status
);

	localparam int IW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);

	dp_cmd_t           cmd;
	dp_stat_t          stat;
	logic              ld_en;
	logic [CW-1:0]     addr;
	logic [CW-1:0]     count;
	logic [IW-1:0]     best_idx;
	logic [CW-1:0]     lmod;
	logic [MODE_W-1:0] mode;
	logic              thr_en;

	assign cfg_ready = 1'b1;

	pssel_ctrl #(
		.MAX_POINTS(MAX_POINTS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.start_index(start_index),
		.fell_back(fell_back),
		.status(status),
		.ld_en(ld_en),
		.cmd(cmd),
		.addr(addr),
		.stat(stat),
		.count(count),
		.best_idx(best_idx),
		.lmod(lmod),
		.mode(mode),
		.thr_en(thr_en)
	);

	pssel_datapath #(
		.MAX_POINTS(MAX_POINTS),
		.COORD_BITS(COORD_BITS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr(cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.ld_en(ld_en),
		.ld_first(first_point),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.layer(layer),
		.cmd(cmd),
		.addr(addr),
		.stat(stat),
		.count(count),
		.best_idx(best_idx),
		.lmod(lmod),
		.mode(mode),
		.thr_en(thr_en)
	);

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// testbench for polyline_start_point_selector: loads polylines, issues queries in every
// selection mode and checks each result against a predictor kept in a scoreboard class
// depends on pssel_pkg and polyline_start_point_selector
module tb;
	import pssel_pkg::*;

	localparam int NPTS = MAX_POINTS_DEF;
	localparam int CB   = COORD_BITS_DEF;

	typedef struct {
		logic [IDX_OUT_W-1:0] idx;
		logic                 fb;
		logic [STATUS_W-1:0]  st;
	} start_choice_t;

	class start_point_scoreboard;
		longint           px[NPTS];
		longint           py[NPTS];
		int unsigned      count;
		bit               overflow;
		logic [MODE_W-1:0] mode;
		bit               thr_en;
		longint unsigned  dthr;
		longint unsigned  wthr;
		start_choice_t    expected_starts[$];
		int               errors;

		function new();
			count = 0; overflow = 0; mode = MODE_NEAREST; thr_en = 0;
			dthr = 0; wthr = 0; errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
			case (idx)
				CFG_SELECT_MODE: mode = data[MODE_W-1:0];
				CFG_THR_ENABLE:  thr_en = data[0];
				CFG_DIST_THR:    dthr = 64'(data[DTHR_W-1:0]);
				CFG_WALK_THR:    wthr = 64'(data[WTHR_W-1:0]);
				default: ;
			endcase
		endfunction

		function longint unsigned dsq(longint ax, longint ay, longint bx, longint by);
			longint unsigned dx, dy;
			dx = (ax >= bx) ? ax - bx : bx - ax;
			dy = (ay >= by) ? ay - by : by - ay;
			return dx * dx + dy * dy;
		endfunction

		function longint unsigned root(longint unsigned v);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v) b >>= 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		function int unsigned scan(longint qx, longint qy, bit nearest,
				longint unsigned bound, output bit found);
			longint unsigned best, d;
			int unsigned pick;
			best = bound; pick = 0; found = 0;
			for (int unsigned i = 0; i < count; i++) begin
				d = dsq(px[i], py[i], qx, qy);
				if (nearest ? (d < best) : (d > best)) begin
					best = d; pick = i; found = 1;
				end
			end
			return pick;
		endfunction

		function int unsigned walk_end(int unsigned lyr);
			int unsigned n, s, p, c;
			longint unsigned sum;
			n = count;
			s = (lyr % n + n - (2 % n)) % n;
			p = s; sum = 0;
			forever begin
				c = (p + 1) % n;
				sum += root(dsq(px[p], py[p], px[c], py[c]));
				if (c == s || sum >= wthr) break;
				p = c;
			end
			return c;
		endfunction

		function void note_item(logic k, logic signed [CB-1:0] x, logic signed [CB-1:0] y,
				logic fp, logic [LAYER_W-1:0] lyr);
			start_choice_t e;
			int unsigned pick;
			bit found;
			longint unsigned t2;
			if (k == KIND_LOAD) begin
				if (fp) begin
					count = 0; overflow = 0;
				end
				if (count < NPTS) begin
					px[count] = longint'(x); py[count] = longint'(y); count++;
				end else begin
					overflow = 1;
				end
				return;
			end
			pick = 0; e.fb = 0;
			if (count == 0) begin
				e.st = ST_EMPTY;
			end else begin
				e.st = overflow ? ST_DROPPED : ST_OK;
				if (mode == MODE_WALK) begin
					pick = walk_end(32'(lyr));
				end else begin
					t2 = dthr * dthr;
					if (mode == MODE_FARTHEST)
						pick = scan(longint'(x), longint'(y), 0, thr_en ? t2 : 64'd0, found);
					else if (mode == MODE_NEAREST && thr_en)
						pick = scan(longint'(x), longint'(y), 1, t2, found);
					else
						pick = scan(longint'(x), longint'(y), 1, 64'hFFFF_FFFF_FFFF_FFFF,
							found);
					if (!found) begin
						e.fb = 1;
						pick = scan(longint'(x), longint'(y), 0, 64'd0, found);
						if (!found) pick = 0;
					end
				end
			end
			e.idx = pick[IDX_OUT_W-1:0];
			expected_starts = {expected_starts, e};
		endfunction

		function void check_result(logic [IDX_OUT_W-1:0] idx, logic fb, logic [STATUS_W-1:0] st);
			start_choice_t e;
			if (expected_starts.size() == 0) begin
				$display("%0t: unexpected result start_index %0d fell_back %0d status %0d",
					$time, idx, fb, st);
				errors++;
				return;
			end
			e = expected_starts.pop_front();
			if (idx !== e.idx) begin
				$display("%0t: start_index expected %0d actual %0d", $time, e.idx, idx);
				errors++;
			end
			if (fb !== e.fb) begin
				$display("%0t: fell_back expected %0d actual %0d", $time, e.fb, fb);
				errors++;
			end
			if (st !== e.st) begin
				$display("%0t: status expected %0d actual %0d", $time, e.st, st);
				errors++;
			end
		endfunction

		function int pending();
			return expected_starts.size();
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DAT_W-1:0]   cfg_data;
	logic                   in_valid;
	logic                   in_ready;
	logic                   kind;
	logic signed [CB-1:0]   pos_x;
	logic signed [CB-1:0]   pos_y;
	logic                   first_point;
	logic [LAYER_W-1:0]     layer;
	logic                   out_valid;
	logic                   out_ready;
	logic [IDX_OUT_W-1:0]   start_index;
	logic                   fell_back;
	logic [STATUS_W-1:0]    status;

	start_point_scoreboard sb = new();
	int idle_pct;
	int stall_pct;
	int holdoff_cycles;

	polyline_start_point_selector i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .kind(kind), .pos_x(pos_x), .pos_y(pos_y),
		.first_point(first_point), .layer(layer),
		.out_valid(out_valid), .out_ready(out_ready), .start_index(start_index),
		.fell_back(fell_back), .status(status)
	);

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	initial begin
		#10ms;
		$display("polyline_start_point_selector: mismatch");
		$finish;
	end

	// receiver side, long hold-off counted here
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (holdoff_cycles > 0) begin
				out_ready = 1'b0;
				holdoff_cycles--;
			end else begin
				out_ready = ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(start_index, fell_back, status);
	end

	// all tasks are entered and left at a falling edge
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
		cfg_valid = 1'b1; cfg_index = idx; cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic send(logic k, logic signed [CB-1:0] x, logic signed [CB-1:0] y,
			logic fp, logic [LAYER_W-1:0] lyr);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1; kind = k; pos_x = x; pos_y = y; first_point = fp; layer = lyr;
		do @(posedge clk); while (!in_ready);
		sb.note_item(k, x, y, fp, lyr);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic drain();
		while (sb.pending() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic configure(logic [MODE_W-1:0] m, logic te, logic [DTHR_W-1:0] dt,
			logic [WTHR_W-1:0] wt);
		drain();
		write_reg(CFG_SELECT_MODE, CFG_DAT_W'(m));
		write_reg(CFG_THR_ENABLE, CFG_DAT_W'(te));
		write_reg(CFG_DIST_THR, CFG_DAT_W'(dt));
		write_reg(CFG_WALK_THR, CFG_DAT_W'(wt));
	endtask

	function automatic logic signed [CB-1:0] rand_coord(int scale);
		case (scale)
			0: return CB'($urandom());
			1: return $urandom_range(0, 1) ? CB'(-(1 <<< (CB - 1))) : CB'((1 <<< (CB - 1)) - 1);
			2: return CB'($signed($urandom_range(0, 511)) - 256);
			default: return CB'($signed($urandom_range(0, 6)) - 3);
		endcase
	endfunction

	task automatic polyline_burst(int scale, int n, int nq);
		for (int i = 0; i < n; i++)
			send(KIND_LOAD, rand_coord(scale), rand_coord(scale), i == 0, LAYER_W'($urandom()));
		for (int i = 0; i < nq; i++)
			send(KIND_QUERY, rand_coord(scale), rand_coord(scale), 1'($urandom()),
				LAYER_W'($urandom()));
	endtask

	localparam logic signed [CB-1:0] CMIN = CB'(-(1 <<< (CB - 1)));
	localparam logic signed [CB-1:0] CMAX = CB'((1 <<< (CB - 1)) - 1);

	initial begin
		int sent;
		int scale;
		int n;
		int nq;
		logic [DTHR_W-1:0] dt;
		logic [WTHR_W-1:0] wt;
		arst_n = 1'b0;
		cfg_valid = 1'b0; cfg_index = CFG_SELECT_MODE; cfg_data = '0;
		in_valid = 1'b0; kind = KIND_LOAD; pos_x = '0; pos_y = '0; first_point = 1'b0;
		layer = '0;
		idle_pct = 0; stall_pct = 0; holdoff_cycles = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty polyline, extremes, coincident points, each mode
		send(KIND_QUERY, CMIN, CMAX, 1'b0, 16'hFFFF);
		send(KIND_LOAD, CMIN, CMIN, 1'b1, 16'h0);
		send(KIND_LOAD, CMAX, CMAX, 1'b0, 16'h0);
		send(KIND_LOAD, CMIN, CMAX, 1'b0, 16'h0);
		send(KIND_QUERY, CMAX, CMAX, 1'b0, 16'h0);
		configure(MODE_FARTHEST, 1'b0, '0, '1);
		send(KIND_QUERY, CMIN, CMIN, 1'b0, 16'h0);
		send(KIND_LOAD, 24'sd5, 24'sd5, 1'b1, 16'h0);
		send(KIND_LOAD, 24'sd5, 24'sd5, 1'b0, 16'h0);
		send(KIND_QUERY, 24'sd5, 24'sd5, 1'b0, 16'h0);
		configure(MODE_NEAREST, 1'b1, 25'd3, '1);
		send(KIND_LOAD, 24'sd9, -24'sd9, 1'b0, 16'h0);
		send(KIND_QUERY, 24'sd5, 24'sd5, 1'b0, 16'h0);
		send(KIND_QUERY, -24'sd100, 24'sd0, 1'b0, 16'h0);
		configure(MODE_FARTHEST, 1'b1, '1, '1);
		send(KIND_QUERY, CMIN, CMIN, 1'b0, 16'h0);
		configure(MODE_WALK, 1'b0, '0, '1);
		send(KIND_QUERY, 24'sd0, 24'sd0, 1'b0, 16'h0);
		send(KIND_QUERY, 24'sd0, 24'sd0, 1'b0, 16'h1);
		send(KIND_LOAD, CMAX, CMIN, 1'b1, 16'h0);
		send(KIND_QUERY, 24'sd0, 24'sd0, 1'b0, 16'hFFFF);
		configure(MODE_PLAIN, 1'b1, 25'd0, '0);
		send(KIND_QUERY, CMIN, CMAX, 1'b0, 16'h0);

		// random phases, all modes with and without threshold
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 76; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 76; end
				default: begin idle_pct = 12; stall_pct = 12; end
			endcase
			if (ph == 0) begin
				dt = '1; wt = '1;
			end else if (ph == 1) begin
				dt = '0; wt = '0;
			end else begin
				dt = DTHR_W'($urandom_range(0, 1) ? $urandom_range(0, 400) : $urandom());
				wt = WTHR_W'($urandom_range(0, 1) ? 64'($urandom_range(0, 2000)) :
					{$urandom(), $urandom()});
			end
			configure(ph[1:0], ph[2], dt, wt);
			if (ph == 3) holdoff_cycles = 400;
			sent = 0;
			while (sent < 10) begin
				scale = $urandom_range(0, 3);
				if ($urandom_range(0, 9) == 0) begin
					send(1'($urandom()), rand_coord(scale), rand_coord(scale), 1'($urandom()),
						LAYER_W'($urandom()));
					sent++;
				end else begin
					n = $urandom_range(1, 12);
					nq = $urandom_range(1, 3);
					polyline_burst(scale, n, nq);
					sent += n + nq;
				end
			end
		end

		// capacity: fill beyond the store, then query the dropped state
		idle_pct = 0; stall_pct = 12;
		configure(MODE_FARTHEST, 1'b0, '0, '0);
		polyline_burst(0, NPTS + 3, 2);
		configure(MODE_NEAREST, 1'b1, 25'd1000000, '0);
		send(KIND_QUERY, rand_coord(0), rand_coord(0), 1'b0, 16'h0);
		configure(MODE_WALK, 1'b0, '0, 35'd1);
		send(KIND_QUERY, 24'sd0, 24'sd0, 1'b0, LAYER_W'($urandom()));
		polyline_burst(2, 3, 2);

		drain();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("polyline_start_point_selector: match");
		else
			$display("polyline_start_point_selector: mismatch");
		$finish;
	end
endmodule
